[rtl/core/fgab_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fgab_pkg
// Shared constants, codes and types of the graded absorbing boundary unit.
// ----------------------------------------------------------------------------
package fgab_pkg;

    // Sizes
    localparam int MAX_DIM    = 4096;
    localparam int MAX_LAYERS = 64;
    localparam int TBL_AW     = $clog2(MAX_LAYERS);
    localparam int DIV_W      = 44;

    // Field and register widths
    localparam int ACTION_W = 2;
    localparam int POS_W    = 12;
    localparam int FIELD_W  = 32;
    localparam int DIM_W    = 13;
    localparam int LAYER_W  = 7;
    localparam int SIGMA_W  = 24;
    localparam int KAPPA_W  = 24;
    localparam int DT_W     = 16;
    localparam int BTYPE_W  = 2;
    localparam int DECAY_W  = 17;
    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 32;

    // Fixed-point constants
    localparam int          ONE_Q16 = 65536;
    localparam logic [31:0] LN2_Q30 = 32'd744261118;
    localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

    // Field component codes
    localparam logic [ACTION_W-1:0] ACT_EZ  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_HX  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_HY  = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_NOP = 2'd3;

    // Boundary type codes
    localparam logic [BTYPE_W-1:0] BND_PML = 2'd0;
    localparam logic [BTYPE_W-1:0] BND_PEC = 2'd1;
    localparam logic [BTYPE_W-1:0] BND_PMC = 2'd2;

    // Register indexes
    localparam logic [2:0] CFG_GRID_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_GRID_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_PML_LAYERS  = 3'd2;
    localparam logic [2:0] CFG_SIGMA_MAX   = 3'd3;
    localparam logic [2:0] CFG_KAPPA_MAX   = 3'd4;
    localparam logic [2:0] CFG_TIME_STEP   = 3'd5;
    localparam logic [2:0] CFG_X_TYPE      = 3'd6;
    localparam logic [2:0] CFG_Y_TYPE      = 3'd7;

    // Geometry settings seen by the datapath
    typedef struct packed {
        logic [DIM_W-1:0]   grid_width;
        logic [DIM_W-1:0]   grid_height;
        logic [LAYER_W-1:0] pml_layers;
        logic [BTYPE_W-1:0] x_type;
        logic [BTYPE_W-1:0] y_type;
    } geo_cfg_t;

    // Grading settings seen by the table builder
    typedef struct packed {
        logic [LAYER_W-1:0] pml_layers;
        logic [SIGMA_W-1:0] peak_sigma;
        logic [KAPPA_W-1:0] peak_kappa;
        logic [DT_W-1:0]    time_step;
    } bld_cfg_t;

    // One decay table entry
    typedef struct packed {
        logic               active;
        logic [DECAY_W-1:0] decay;
    } tbl_entry_t;

    localparam int TBL_W = $bits(tbl_entry_t);

    // Table write port
    typedef struct packed {
        logic              en;
        logic [TBL_AW-1:0] addr;
        tbl_entry_t        data;
    } tbl_wr_t;

endpackage
`default_nettype wire

[rtl/core/fgab_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fgab_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fgab_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

[rtl/core/fgab_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fgab_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fgab_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [fgab_pkg::DIV_W-1:0] dividend,
    input  wire logic [31:0]                divisor,
    output logic                            done,
    output logic      [fgab_pkg::DIV_W-1:0] quotient
);
    import fgab_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic             run_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0] dvd_reg;
    logic [31:0]      dsr_reg;
    logic [31:0]      rem_reg;
    logic [32:0]      trial;
    logic             qbit;
    logic [32:0]      rem_next;

    // Trial subtraction
    always_comb
    begin
        trial    = {rem_reg, dvd_reg[DIV_W-1]};
        qbit     = (trial >= {1'b0, dsr_reg});
        rem_next = qbit ? (trial - {1'b0, dsr_reg}) : trial;
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(DIV_W);
        end
        else if (run_reg)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            run_reg  <= (cnt_reg != CNT_W'(1));
            done_reg <= (cnt_reg == CNT_W'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Dividend shifts out, quotient bits shift in
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end
        else if (run_reg)
        begin
            dvd_reg <= {dvd_reg[DIV_W-2:0], qbit};
            rem_reg <= rem_next[31:0];
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule
`default_nettype wire

[rtl/core/fgab_table_builder.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fgab_table_builder
// Sequencer that fills the decay table, one layer depth at a time, with a
// shared multiplier and a shared divider.
// ----------------------------------------------------------------------------
module fgab_table_builder (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire fgab_pkg::bld_cfg_t  cfg,
    output logic                     busy,
    output fgab_pkg::tbl_wr_t        tbl_wr
);
    import fgab_pkg::*;

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b0000000001,
        ST_SETUP  = 10'b0000000010,
        ST_MUL    = 10'b0000000100,
        ST_PROD   = 10'b0000001000,
        ST_DSTART = 10'b0000010000,
        ST_DIV    = 10'b0000100000,
        ST_POST   = 10'b0001000000,
        ST_RED    = 10'b0010000000,
        ST_FIN    = 10'b0100000000,
        ST_WRITE  = 10'b1000000000
    } bld_state_t;

    typedef enum logic [2:0] {
        OP_SIG = 3'd0,
        OP_KAP = 3'd1,
        OP_X   = 3'd2,
        OP_T   = 3'd3
    } bld_op_t;

    bld_state_t          state_reg, state_next;
    bld_op_t             op_reg;
    logic [LAYER_W-1:0]  l_reg;
    logic [12:0]         l2_reg;
    logic [18:0]         l3_reg;
    logic [KAPPA_W-1:0]  kmm_reg;
    logic [LAYER_W-1:0]  d_reg;
    logic [SIGMA_W-1:0]  sig_reg;
    logic [24:0]         kap_reg;
    logic [37:0]         rr_reg;
    logic [4:0]          k_reg;
    logic [29:0]         r_reg;
    logic [30:0]         t_reg;
    logic signed [32:0]  sum_reg;
    logic [3:0]          n_reg;
    logic [31:0]         mul_a_reg, mul_b_reg, dsr_reg;
    logic [63:0]         prod_reg;
    tbl_entry_t          entry_reg;

    logic [LAYER_W-1:0]  lc;
    logic [12:0]         lc2;
    logic [18:0]         lc3;
    logic [12:0]         d2;
    logic [18:0]         d3;
    logic [37:0]         ln2_w;
    logic                red_ge;
    logic [DIV_W-1:0]    dividend;
    logic                div_start;
    logic                div_done;
    logic [DIV_W-1:0]    q;
    logic signed [32:0]  qs;
    logic [31:0]         e;
    logic [4:0]          sh;
    logic [32:0]         rnd;

    // Small products of depth and layer count
    always_comb
    begin
        lc     = (cfg.pml_layers > LAYER_W'(MAX_LAYERS)) ? LAYER_W'(MAX_LAYERS)
                                                         : cfg.pml_layers;
        lc2    = 13'(lc * lc);
        lc3    = 19'(lc2 * lc);
        d2     = 13'(d_reg * d_reg);
        d3     = 19'(d2 * d_reg);
        ln2_w  = {6'd0, LN2_Q30};
        red_ge = (rr_reg >= ln2_w);
        qs     = $signed({2'b00, q[30:0]});
    end

    // Taylor quotient terms are taken from the top of the product
    assign dividend  = (op_reg == OP_T) ? DIV_W'(prod_reg[63:30]) : prod_reg[DIV_W-1:0];
    assign div_start = (state_reg == ST_DSTART);

    fgab_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (dsr_reg),
        .done     (div_done),
        .quotient (q)
    );

    // Final rounding of exp(-r) by 2^(14+k)
    always_comb
    begin
        e   = sum_reg[32] ? 32'd0 : sum_reg[31:0];
        sh  = 5'd14 + k_reg;
        rnd = {1'b0, e} + (33'd1 << (sh - 5'd1));
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (start) state_next = ST_SETUP;
            ST_SETUP:  state_next = (lc == '0) ? ST_IDLE : ST_MUL;
            ST_MUL:    state_next = ST_PROD;
            ST_PROD:   state_next = ST_DSTART;
            ST_DSTART: state_next = ST_DIV;
            ST_DIV:    if (div_done) state_next = ST_POST;
            ST_POST:
            begin
                case (op_reg)
                    OP_SIG:  state_next = (q == '0) ? ST_WRITE : ST_MUL;
                    OP_X:    state_next = ST_RED;
                    OP_T:    state_next = (n_reg == 4'd12) ? ST_FIN : ST_MUL;
                    default: state_next = ST_MUL;
                endcase
            end
            // Strip whole multiples of ln2; seventeen or more give a zero decay
            ST_RED:
            begin
                if (red_ge)
                    state_next = (k_reg == 5'd16) ? ST_WRITE : ST_RED;
                else
                    state_next = ST_MUL;
            end
            ST_FIN:    state_next = ST_WRITE;
            ST_WRITE:  state_next = (d_reg == l_reg) ? ST_IDLE : ST_MUL;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a_reg * mul_b_reg;
        case (state_reg)
            ST_SETUP:
            begin
                l_reg   <= lc;
                l2_reg  <= lc2;
                l3_reg  <= lc3;
                kmm_reg <= (cfg.peak_kappa < KAPPA_W'(ONE_Q16)) ? '0
                                                                : cfg.peak_kappa - KAPPA_W'(ONE_Q16);
                d_reg   <= LAYER_W'(1);
                op_reg  <= OP_SIG;
            end
            ST_MUL:
            begin
                case (op_reg)
                    OP_SIG:
                    begin
                        mul_a_reg <= 32'(cfg.peak_sigma);
                        mul_b_reg <= 32'(d3);
                        dsr_reg   <= 32'(l3_reg);
                    end
                    OP_KAP:
                    begin
                        mul_a_reg <= 32'(kmm_reg);
                        mul_b_reg <= 32'(d2);
                        dsr_reg   <= 32'(l2_reg);
                    end
                    OP_X:
                    begin
                        mul_a_reg <= 32'(sig_reg);
                        mul_b_reg <= 32'(cfg.time_step);
                        dsr_reg   <= 32'(kap_reg);
                    end
                    default:
                    begin
                        mul_a_reg <= 32'(t_reg);
                        mul_b_reg <= 32'(r_reg);
                        dsr_reg   <= 32'(n_reg);
                    end
                endcase
            end
            ST_POST:
            begin
                case (op_reg)
                    OP_SIG:
                    begin
                        sig_reg   <= q[SIGMA_W-1:0];
                        entry_reg <= '{active: 1'b0, decay: DECAY_W'(ONE_Q16)};
                        op_reg    <= OP_KAP;
                    end
                    OP_KAP:
                    begin
                        kap_reg <= 25'(ONE_Q16) + q[24:0];
                        op_reg  <= OP_X;
                    end
                    OP_X:
                    begin
                        rr_reg    <= {q[23:0], 14'd0};
                        k_reg     <= '0;
                        entry_reg <= '{active: 1'b1, decay: '0};
                        op_reg    <= OP_T;
                    end
                    default:
                    begin
                        t_reg   <= q[30:0];
                        sum_reg <= n_reg[0] ? (sum_reg - qs) : (sum_reg + qs);
                        n_reg   <= n_reg + 4'd1;
                    end
                endcase
            end
            ST_RED:
            begin
                if (red_ge)
                begin
                    rr_reg <= rr_reg - ln2_w;
                    k_reg  <= k_reg + 5'd1;
                end
                else
                begin
                    r_reg   <= rr_reg[29:0];
                    t_reg   <= ONE_Q30[30:0];
                    sum_reg <= $signed({1'b0, ONE_Q30});
                    n_reg   <= 4'd1;
                end
            end
            ST_FIN:
            begin
                entry_reg <= '{active: 1'b1, decay: DECAY_W'(rnd >> sh)};
            end
            ST_WRITE:
            begin
                d_reg  <= d_reg + LAYER_W'(1);
                op_reg <= OP_SIG;
            end
            default:
            begin
            end
        endcase
    end

    assign busy        = (state_reg != ST_IDLE);
    assign tbl_wr.en   = (state_reg == ST_WRITE);
    assign tbl_wr.addr = TBL_AW'(d_reg - LAYER_W'(1));
    assign tbl_wr.data = entry_reg;

endmodule
`default_nettype wire

[rtl/core/fgab_pipe.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fgab_pipe
// Six-stage sample datapath: depth, table read, decay combine, round, scale,
// saturate.
// ----------------------------------------------------------------------------
module fgab_pipe (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic [fgab_pkg::ACTION_W-1:0] action,
    input  wire logic [fgab_pkg::POS_W-1:0]    col,
    input  wire logic [fgab_pkg::POS_W-1:0]    row,
    input  wire logic [fgab_pkg::FIELD_W-1:0]  field_in,
    input  wire fgab_pkg::geo_cfg_t            geo,
    input  wire fgab_pkg::tbl_wr_t             tbl_wr,
    output logic                               out_valid,
    output logic      [fgab_pkg::FIELD_W-1:0]  field_out,
    output logic                               attenuated,
    output logic                               forced_zero
);
    import fgab_pkg::*;

    // Depth into the layer along one axis, right/top edge first
    function automatic logic [LAYER_W-1:0] layer_depth(
        input logic [POS_W-1:0]   pos,
        input logic [DIM_W-1:0]   dim,
        input logic [LAYER_W-1:0] l
    );
        logic [DIM_W:0]     pl;
        logic [DIM_W:0]     dd;
        logic [LAYER_W-1:0] res;
        pl  = {2'b00, pos} + (DIM_W + 1)'(l);
        dd  = pl + (DIM_W + 1)'(1) - {1'b0, dim};
        res = '0;
        if (l == '0)
            res = '0;
        else if (pl >= {1'b0, dim})
            res = (dd > (DIM_W + 1)'(l)) ? l : dd[LAYER_W-1:0];
        else if ({1'b0, pos} < (POS_W + 1)'(l))
            res = l - pos[LAYER_W-1:0];
        return res;
    endfunction

    logic [DIM_W-1:0]   w_eff, h_eff;
    logic [LAYER_W-1:0] l_eff;
    logic               x_edge, y_edge, gate, zero;
    logic [FIELD_W-1:0] mag;

    // Stage 1 registers
    logic               v1_reg, neg1_reg, gate1_reg, zero1_reg;
    logic [ACTION_W-1:0] act1_reg;
    logic [FIELD_W-1:0] mag1_reg, raw1_reg;
    logic [LAYER_W-1:0] dpx1_reg, dpy1_reg;
    // Stage 2 registers
    logic               v2_reg, neg2_reg, gate2_reg, zero2_reg, inx2_reg, iny2_reg;
    logic [ACTION_W-1:0] act2_reg;
    logic [FIELD_W-1:0] mag2_reg, raw2_reg;
    // Stage 3 registers
    logic               v3_reg, neg3_reg, att3_reg, zero3_reg, ez3_reg;
    logic [FIELD_W-1:0] mag3_reg, raw3_reg;
    logic [33:0]        pd3_reg;
    logic [DECAY_W-1:0] sel3_reg;
    // Stage 4 registers
    logic               v4_reg, neg4_reg, att4_reg, zero4_reg;
    logic [FIELD_W-1:0] mag4_reg, raw4_reg;
    logic [DECAY_W-1:0] decay4_reg;
    // Stage 5 registers
    logic               v5_reg, neg5_reg, att5_reg, zero5_reg;
    logic [FIELD_W-1:0] raw5_reg;
    logic [48:0]        prod5_reg;
    // Output registers
    logic               out_valid_reg, att_out_reg, zero_out_reg;
    logic [FIELD_W-1:0] field_out_reg;

    logic [TBL_W-1:0]   ramx_q, ramy_q;
    tbl_entry_t         ex, ey;
    logic [DECAY_W-1:0] dx, dy;
    logic               ax, ay, att2;
    logic [DECAY_W-1:0] decay3;
    logic [33:0]        pd_rnd;
    logic [48:0]        rnd5;
    logic [32:0]        res5, sat5;
    logic [FIELD_W-1:0] result5;

    // Stage 1: clamp geometry, find depths, edges and edge rules
    always_comb
    begin
        w_eff  = (geo.grid_width  > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : geo.grid_width;
        h_eff  = (geo.grid_height > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : geo.grid_height;
        l_eff  = (geo.pml_layers > LAYER_W'(MAX_LAYERS)) ? LAYER_W'(MAX_LAYERS)
                                                         : geo.pml_layers;
        x_edge = (col == '0) || ((w_eff != '0) && ({1'b0, col} == w_eff - DIM_W'(1)));
        y_edge = (row == '0) || ((h_eff != '0) && ({1'b0, row} == h_eff - DIM_W'(1)));
        gate   = (action != ACT_NOP) && ((geo.x_type == BND_PML) || (geo.y_type == BND_PML));
        case (action)
            ACT_EZ:  zero = ((geo.x_type == BND_PEC) && x_edge) ||
                            ((geo.y_type == BND_PEC) && y_edge);
            ACT_HX:  zero = (geo.y_type == BND_PMC) && y_edge;
            ACT_HY:  zero = (geo.x_type == BND_PMC) && x_edge;
            default: zero = 1'b0;
        endcase
        mag = field_in[FIELD_W-1] ? (~field_in + FIELD_W'(1)) : field_in;
    end

    always_ff @(posedge clk)
    begin
        act1_reg  <= action;
        neg1_reg  <= field_in[FIELD_W-1];
        mag1_reg  <= mag;
        raw1_reg  <= field_in;
        gate1_reg <= gate;
        zero1_reg <= zero;
        dpx1_reg  <= layer_depth(col, w_eff, l_eff);
        dpy1_reg  <= layer_depth(row, h_eff, l_eff);
    end

    // Decay tables, one read port per axis
    fgab_ram #(
        .WIDTH (TBL_W),
        .DEPTH (MAX_LAYERS)
    ) u_ram_x (
        .clk     (clk),
        .wr_en   (tbl_wr.en),
        .wr_addr (tbl_wr.addr),
        .wr_data (tbl_wr.data),
        .rd_addr (TBL_AW'(dpx1_reg - LAYER_W'(1))),
        .rd_data (ramx_q)
    );

    fgab_ram #(
        .WIDTH (TBL_W),
        .DEPTH (MAX_LAYERS)
    ) u_ram_y (
        .clk     (clk),
        .wr_en   (tbl_wr.en),
        .wr_addr (tbl_wr.addr),
        .wr_data (tbl_wr.data),
        .rd_addr (TBL_AW'(dpy1_reg - LAYER_W'(1))),
        .rd_data (ramy_q)
    );

    // Stage 2: pass the sample alongside the table read
    always_ff @(posedge clk)
    begin
        act2_reg  <= act1_reg;
        neg2_reg  <= neg1_reg;
        mag2_reg  <= mag1_reg;
        raw2_reg  <= raw1_reg;
        gate2_reg <= gate1_reg;
        zero2_reg <= zero1_reg;
        inx2_reg  <= (dpx1_reg != '0);
        iny2_reg  <= (dpy1_reg != '0);
    end

    // Stage 3: pick axis decays, product of both for Ez
    always_comb
    begin
        ex = tbl_entry_t'(ramx_q);
        ey = tbl_entry_t'(ramy_q);
        dx = inx2_reg ? ex.decay : DECAY_W'(ONE_Q16);
        dy = iny2_reg ? ey.decay : DECAY_W'(ONE_Q16);
        ax = inx2_reg && ex.active;
        ay = iny2_reg && ey.active;
        case (act2_reg)
            ACT_EZ:  att2 = gate2_reg && (ax || ay);
            ACT_HX:  att2 = gate2_reg && ay;
            ACT_HY:  att2 = gate2_reg && ax;
            default: att2 = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        neg3_reg  <= neg2_reg;
        mag3_reg  <= mag2_reg;
        raw3_reg  <= raw2_reg;
        zero3_reg <= zero2_reg;
        att3_reg  <= att2;
        ez3_reg   <= (act2_reg == ACT_EZ);
        pd3_reg   <= 34'(dx * dy);
        sel3_reg  <= (act2_reg == ACT_HX) ? dy : dx;
    end

    // Stage 4: round the combined decay
    always_comb
    begin
        pd_rnd = pd3_reg + 34'd32768;
        decay3 = ez3_reg ? DECAY_W'(pd_rnd >> 16) : sel3_reg;
    end

    always_ff @(posedge clk)
    begin
        neg4_reg   <= neg3_reg;
        mag4_reg   <= mag3_reg;
        raw4_reg   <= raw3_reg;
        zero4_reg  <= zero3_reg;
        att4_reg   <= att3_reg;
        decay4_reg <= decay3;
    end

    // Stage 5: scale the magnitude
    always_ff @(posedge clk)
    begin
        neg5_reg  <= neg4_reg;
        raw5_reg  <= raw4_reg;
        zero5_reg <= zero4_reg;
        att5_reg  <= att4_reg;
        prod5_reg <= 49'(mag4_reg * decay4_reg);
    end

    // Output: round, saturate, restore sign, pass through unattenuated samples, apply edge rule
    always_comb
    begin
        rnd5 = prod5_reg + 49'd32768;
        res5 = rnd5[48:16];
        if (neg5_reg)
        begin
            sat5    = (res5 > 33'h0_8000_0000) ? 33'h0_8000_0000 : res5;
            result5 = FIELD_W'(0) - sat5[FIELD_W-1:0];
        end
        else
        begin
            sat5    = (res5 > 33'h0_7FFF_FFFF) ? 33'h0_7FFF_FFFF : res5;
            result5 = sat5[FIELD_W-1:0];
        end
        if (!att5_reg)
            result5 = raw5_reg;
        if (zero5_reg)
            result5 = '0;
    end

    always_ff @(posedge clk)
    begin
        field_out_reg <= result5;
        att_out_reg   <= att5_reg;
        zero_out_reg  <= zero5_reg;
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            v5_reg        <= v4_reg;
            out_valid_reg <= v5_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign field_out   = field_out_reg;
    assign attenuated  = att_out_reg;
    assign forced_zero = zero_out_reg;

endmodule
`default_nettype wire

[rtl/core/fdtd_graded_absorber_boundary_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdtd_graded_absorber_boundary_unit
// Graded absorbing boundary for 2D FDTD field samples with PEC/PMC edge rules.
//
// Channel   Direction  Handshake               Payload
// command   in         start high, busy low    action, col, row, field_in
// result    out        done strobe, one cycle  field_out, attenuated, forced_zero
// config    in/out     APB write/read          paddr, pwdata, prdata
//
// One sample per clock while busy is low; each result is registered through
// the six register stages of the datapath.
// After reset, and after a write to any grading register (layer count, peak
// conductivity, peak stretch or time step), busy stays high while the decay
// table is rebuilt by the shared bit-serial divider (up to 15 divisions for
// each layer depth).
// The result strobe is not held off; done is high for exactly one cycle.
// ----------------------------------------------------------------------------
module fdtd_graded_absorber_boundary_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [fgab_pkg::ACTION_W-1:0] action,
    input  wire logic [fgab_pkg::POS_W-1:0]    col,
    input  wire logic [fgab_pkg::POS_W-1:0]    row,
    input  wire logic [fgab_pkg::FIELD_W-1:0]  field_in,
    output logic                               done,
    output logic      [fgab_pkg::FIELD_W-1:0]  field_out,
    output logic                               attenuated,
    output logic                               forced_zero,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [fgab_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [fgab_pkg::PDATA_W-1:0]  pwdata,
    output logic      [fgab_pkg::PDATA_W-1:0]  prdata,
    output logic                               pready
);
    import fgab_pkg::*;

    logic [DIM_W-1:0]   grid_width_reg, grid_height_reg;
    logic [LAYER_W-1:0] pml_layers_reg;
    logic [SIGMA_W-1:0] peak_sigma_reg;
    logic [KAPPA_W-1:0] peak_kappa_reg;
    logic [DT_W-1:0]    time_step_reg;
    logic [BTYPE_W-1:0] x_type_reg, y_type_reg;
    logic               pend_reg;

    logic               wr;
    logic [2:0]         idx;
    logic               bld_busy;
    logic               bld_start;
    bld_cfg_t           bld_cfg;
    geo_cfg_t           geo;
    tbl_wr_t            tbl_wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;
    assign idx    = paddr[PADDR_W-1:2];

    // Configuration registers; grading changes request a table rebuild
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= DIM_W'(256);
            grid_height_reg <= DIM_W'(256);
            pml_layers_reg  <= LAYER_W'(10);
            peak_sigma_reg  <= SIGMA_W'(52429);
            peak_kappa_reg  <= KAPPA_W'(65536);
            time_step_reg   <= DT_W'(32768);
            x_type_reg      <= BND_PML;
            y_type_reg      <= BND_PML;
            pend_reg        <= 1'b1;
        end
        else
        begin
            if (bld_start)
                pend_reg <= 1'b0;
            if (wr)
            begin
                unique case (idx)
                    CFG_GRID_WIDTH:  grid_width_reg  <= pwdata[DIM_W-1:0];
                    CFG_GRID_HEIGHT: grid_height_reg <= pwdata[DIM_W-1:0];
                    CFG_PML_LAYERS:  pml_layers_reg  <= pwdata[LAYER_W-1:0];
                    CFG_SIGMA_MAX:   peak_sigma_reg  <= pwdata[SIGMA_W-1:0];
                    CFG_KAPPA_MAX:   peak_kappa_reg  <= pwdata[KAPPA_W-1:0];
                    CFG_TIME_STEP:   time_step_reg   <= pwdata[DT_W-1:0];
                    CFG_X_TYPE:      x_type_reg      <= pwdata[BTYPE_W-1:0];
                    CFG_Y_TYPE:      y_type_reg      <= pwdata[BTYPE_W-1:0];
                    default:
                    begin
                    end
                endcase
                case (idx) inside
                    CFG_PML_LAYERS, CFG_SIGMA_MAX, CFG_KAPPA_MAX, CFG_TIME_STEP:
                        pend_reg <= 1'b1;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Read-back
    always_comb
    begin
        unique case (idx)
            CFG_GRID_WIDTH:  prdata = PDATA_W'(grid_width_reg);
            CFG_GRID_HEIGHT: prdata = PDATA_W'(grid_height_reg);
            CFG_PML_LAYERS:  prdata = PDATA_W'(pml_layers_reg);
            CFG_SIGMA_MAX:   prdata = PDATA_W'(peak_sigma_reg);
            CFG_KAPPA_MAX:   prdata = PDATA_W'(peak_kappa_reg);
            CFG_TIME_STEP:   prdata = PDATA_W'(time_step_reg);
            CFG_X_TYPE:      prdata = PDATA_W'(x_type_reg);
            CFG_Y_TYPE:      prdata = PDATA_W'(y_type_reg);
            default:         prdata = '0;
        endcase
    end

    assign bld_start = pend_reg && !bld_busy;
    assign busy      = pend_reg || bld_busy;

    assign bld_cfg.pml_layers = pml_layers_reg;
    assign bld_cfg.peak_sigma = peak_sigma_reg;
    assign bld_cfg.peak_kappa = peak_kappa_reg;
    assign bld_cfg.time_step  = time_step_reg;

    assign geo.grid_width  = grid_width_reg;
    assign geo.grid_height = grid_height_reg;
    assign geo.pml_layers  = pml_layers_reg;
    assign geo.x_type      = x_type_reg;
    assign geo.y_type      = y_type_reg;

    fgab_table_builder u_builder (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (bld_start),
        .cfg    (bld_cfg),
        .busy   (bld_busy),
        .tbl_wr (tbl_wr)
    );

    fgab_pipe u_pipe (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (start && !busy),
        .action      (action),
        .col         (col),
        .row         (row),
        .field_in    (field_in),
        .geo         (geo),
        .tbl_wr      (tbl_wr),
        .out_valid   (done),
        .field_out   (field_out),
        .attenuated  (attenuated),
        .forced_zero (forced_zero)
    );

endmodule
`default_nettype wire

[rtl/core/fgab_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fgab_checker
// Port-level checks of latency, pass-through and edge-rule results.
// ----------------------------------------------------------------------------
module fgab_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          start,
    input wire logic                          busy,
    input wire logic [fgab_pkg::ACTION_W-1:0] action,
    input wire logic [fgab_pkg::FIELD_W-1:0]  field_in,
    input wire logic                          done,
    input wire logic [fgab_pkg::FIELD_W-1:0]  field_out,
    input wire logic                          attenuated,
    input wire logic                          forced_zero
);
    import fgab_pkg::*;

    // Every transaction yields its result on done
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##6 done)
        else $error("result missing six cycles after transaction");

    // A zeroed sample reads as zero
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && forced_zero) |-> (field_out == '0))
        else $error("forced_zero set with nonzero field_out");

    // Untouched samples pass through unchanged
    a_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !attenuated && !forced_zero) |-> (field_out == $past(field_in, 6)))
        else $error("pass-through sample altered");

    // The unused component code never raises a flag
    a_code3: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (attenuated || forced_zero)) |-> ($past(action, 6) != ACT_NOP))
        else $error("flag raised for unused component code");

endmodule

bind fdtd_graded_absorber_boundary_unit fgab_checker u_fgab_checker (.*);
`default_nettype wire
